@@ rtl/brtt_pkg.sv @@
package brtt_pkg;

    // Default sizes of the table.
    localparam int ENTRIES_DEF   = 64;
    localparam int ADDR_BITS_DEF = 32;

    // Width of the reported slot number.
    localparam int SLOT_W = 6;

    typedef logic [SLOT_W-1:0] t_slot;

    // Command codes of an input item.
    localparam logic CMD_INSERT    = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_MISS   = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;
    localparam logic [1:0] STATUS_REJECT = 2'd3;

    // One input beat.
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] handle;
        logic        [31:0] source_base;
        logic        [31:0] target_base;
        logic        [31:0] buffer_bytes;
        logic        [31:0] buffer_count;
        logic        [31:0] lookup_addr;
    } t_in_item;

    // One output beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_addr;
        t_slot       slot_index;
    } t_out_item;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_TR,
        S_TR_FIN
    } t_state;

    // Which result the datapath forms when told to load one.
    typedef enum logic [2:0] {
        RES_STORED,
        RES_FULL,
        RES_REJECT,
        RES_MISS,
        RES_HIT
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     idx_clear;
        logic     idx_inc;
        logic     wr_en;
        logic     wr_use_free;
        logic     hit_latch;
        logic     res_load;
        t_res_sel res_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reject;
        logic addr_zero;
        logic ins_match;
        logic tr_hit;
        logic last;
        logic have_free;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/brtt_ram.sv @@
module brtt_ram #(
    parameter int WIDTH = 32 + 3 * brtt_pkg::ADDR_BITS_DEF,
    parameter int DEPTH = brtt_pkg::ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/brtt_dp.sv @@
module brtt_dp #(
    parameter int ENTRIES   = brtt_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS = brtt_pkg::ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  brtt_pkg::t_in_item    i_in_data,
    input  brtt_pkg::t_dp_cmd     i_cmd,
    output brtt_pkg::t_dp_status  o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output brtt_pkg::t_out_item   o_out_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int MEM_W = 32 + 3 * ADDR_BITS;
    localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);
    localparam logic [63:0] HIGH_MASK = ~ADDR_MASK;

    // Latched item.
    logic [31:0]          r_key;
    logic [ADDR_BITS-1:0] r_src;
    logic [ADDR_BITS-1:0] r_tgt;
    logic [ADDR_BITS-1:0] r_a;
    logic [31:0]          r_addr;
    logic                 r_pre_reject;
    logic [63:0]          r_prod;

    // Scan state.
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     n_idx;
    logic                 r_free_found;
    logic [IDX_W-1:0]     r_free_idx;
    logic [ENTRIES-1:0]   r_valid;

    // Hit capture.
    logic [ADDR_BITS-1:0] r_hit_tgt;
    logic [ADDR_BITS-1:0] r_hit_off;
    logic [IDX_W-1:0]     r_hit_idx;

    // Output register.
    logic                 r_out_valid;
    brtt_pkg::t_out_item  r_out_data;
    brtt_pkg::t_out_item  n_out_data;

    logic [ADDR_BITS-1:0] in_src;
    logic [ADDR_BITS-1:0] in_tgt;
    logic                 in_pre_reject;
    logic [63:0]          in_prod;

    logic [MEM_W-1:0]     rd_data;
    logic [MEM_W-1:0]     wr_data;
    logic [IDX_W-1:0]     wr_idx;
    logic [31:0]          e_key;
    logic [ADDR_BITS-1:0] e_src;
    logic [ADDR_BITS-1:0] e_tgt;
    logic [ADDR_BITS-1:0] e_end;
    logic [ADDR_BITS-1:0] new_end;
    logic [ADDR_BITS-1:0] hit_sum;
    logic                 cur_valid;
    logic                 out_free;

    // Checks that need only the incoming beat, and the region size product.
    assign in_src        = ADDR_BITS'(i_in_data.source_base);
    assign in_tgt        = ADDR_BITS'(i_in_data.target_base);
    assign in_pre_reject = i_in_data.handle[31] || (in_src == '0) || (in_tgt == '0) ||
                           (i_in_data.buffer_count == 32'd0);
    assign in_prod       = 64'(i_in_data.buffer_bytes) * 64'(i_in_data.buffer_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_key        <= i_in_data.handle;
            r_src        <= in_src;
            r_tgt        <= in_tgt;
            r_a          <= ADDR_BITS'(i_in_data.lookup_addr);
            r_addr       <= i_in_data.lookup_addr;
            r_pre_reject <= in_pre_reject;
            r_prod       <= in_prod;
        end
    end

    // Scan index; the RAM reads at the next index so that its data belongs to r_idx.
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clear) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_free_found <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.idx_clear) begin
                r_free_found <= 1'b0;
            end else if (i_cmd.idx_inc && !r_free_found && !cur_valid) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_inc && !r_free_found && !cur_valid) begin
            r_free_idx <= r_idx;
        end
    end

    // Valid marks, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr_en) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    assign cur_valid = r_valid[r_idx];

    // Entry store: key, source base, target base and range end.
    assign new_end = r_src + r_prod[ADDR_BITS-1:0];
    assign wr_data = {r_key, r_src, r_tgt, new_end};
    assign wr_idx  = (i_cmd.wr_use_free && r_free_found) ? r_free_idx : r_idx;

    brtt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    assign e_key = rd_data[MEM_W-1 -: 32];
    assign e_src = rd_data[3*ADDR_BITS-1 -: ADDR_BITS];
    assign e_tgt = rd_data[2*ADDR_BITS-1 -: ADDR_BITS];
    assign e_end = rd_data[ADDR_BITS-1:0];

    // Capture the matching entry; the rebased address is summed in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_latch) begin
            r_hit_tgt <= e_tgt;
            r_hit_off <= r_a - e_src;
            r_hit_idx <= r_idx;
        end
    end

    assign hit_sum = r_hit_tgt + r_hit_off;

    // Status toward the controller. A range with a nonzero length that does
    // not wrap is exactly one whose end lies above an address at or past its base.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status.reject    = r_pre_reject || ((r_prod & HIGH_MASK) != 64'd0);
        o_status.addr_zero = (r_a == '0);
        o_status.ins_match = cur_valid && ((e_key == r_key) || (e_src == r_src));
        o_status.tr_hit    = cur_valid && (e_src != '0) && (e_tgt != '0) &&
                             (r_a >= e_src) && (r_a < e_end);
        o_status.last      = (r_idx == IDX_W'(ENTRIES - 1));
        o_status.have_free = r_free_found || !cur_valid;
        o_status.out_free  = out_free;
    end

    // Result forming.
    always_comb begin
        n_out_data.status      = brtt_pkg::STATUS_MISS;
        n_out_data.result_addr = r_addr;
        n_out_data.slot_index  = '0;
        case (i_cmd.res_sel)
            brtt_pkg::RES_STORED: begin
                n_out_data.status      = brtt_pkg::STATUS_OK;
                n_out_data.result_addr = 32'd0;
                n_out_data.slot_index  = brtt_pkg::t_slot'(wr_idx);
            end
            brtt_pkg::RES_FULL: begin
                n_out_data.status      = brtt_pkg::STATUS_FULL;
                n_out_data.result_addr = 32'd0;
            end
            brtt_pkg::RES_REJECT: begin
                n_out_data.status      = brtt_pkg::STATUS_REJECT;
                n_out_data.result_addr = 32'd0;
            end
            brtt_pkg::RES_HIT: begin
                n_out_data.status      = brtt_pkg::STATUS_OK;
                n_out_data.result_addr = 32'(hit_sum);
                n_out_data.slot_index  = brtt_pkg::t_slot'(r_hit_idx);
            end
            default: begin
                n_out_data.status      = brtt_pkg::STATUS_MISS;
                n_out_data.result_addr = r_addr;
            end
        endcase
    end

    // Output register holds a finished beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/brtt_ctrl.sv @@
module brtt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_cmd,
    input  brtt_pkg::t_dp_status i_status,
    output brtt_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_stall
);

    brtt_pkg::t_state r_state;
    brtt_pkg::t_state n_state;
    logic             accept;

    assign accept = (r_state == brtt_pkg::S_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brtt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            brtt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_cmd == brtt_pkg::CMD_INSERT) ? brtt_pkg::S_INS
                                                                 : brtt_pkg::S_TR;
                end
            end
            brtt_pkg::S_INS: begin
                if (i_status.out_free &&
                    (i_status.reject || i_status.ins_match || i_status.last)) begin
                    n_state = brtt_pkg::S_IDLE;
                end
            end
            brtt_pkg::S_TR: begin
                if (i_status.addr_zero) begin
                    if (i_status.out_free) begin
                        n_state = brtt_pkg::S_IDLE;
                    end
                end else if (i_status.tr_hit) begin
                    n_state = brtt_pkg::S_TR_FIN;
                end else if (i_status.last && i_status.out_free) begin
                    n_state = brtt_pkg::S_IDLE;
                end
            end
            brtt_pkg::S_TR_FIN: begin
                if (i_status.out_free) begin
                    n_state = brtt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = brtt_pkg::S_IDLE;
            end
        endcase
    end

    // Commands. A step that produces a result waits while the output register holds a stalled beat.
    always_comb begin
        o_cmd         = '0;
        o_cmd.res_sel = brtt_pkg::RES_MISS;
        o_in_stall    = 1'b1;
        case (r_state)
            brtt_pkg::S_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.load_in   = accept;
                o_cmd.idx_clear = accept;
            end
            brtt_pkg::S_INS: begin
                if (i_status.reject || i_status.ins_match || i_status.last) begin
                    if (i_status.out_free) begin
                        o_cmd.res_load = 1'b1;
                        if (i_status.reject) begin
                            o_cmd.res_sel = brtt_pkg::RES_REJECT;
                        end else if (i_status.ins_match) begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.res_sel = brtt_pkg::RES_STORED;
                        end else if (i_status.have_free) begin
                            o_cmd.wr_en       = 1'b1;
                            o_cmd.wr_use_free = 1'b1;
                            o_cmd.res_sel     = brtt_pkg::RES_STORED;
                        end else begin
                            o_cmd.res_sel = brtt_pkg::RES_FULL;
                        end
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            brtt_pkg::S_TR: begin
                if (i_status.addr_zero) begin
                    o_cmd.res_load = i_status.out_free;
                    o_cmd.res_sel  = brtt_pkg::RES_MISS;
                end else if (i_status.tr_hit) begin
                    o_cmd.hit_latch = 1'b1;
                end else if (i_status.last) begin
                    o_cmd.res_load = i_status.out_free;
                    o_cmd.res_sel  = brtt_pkg::RES_MISS;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            brtt_pkg::S_TR_FIN: begin
                o_cmd.res_load = i_status.out_free;
                o_cmd.res_sel  = brtt_pkg::RES_HIT;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/buffer_range_translation_table.sv @@
// Channel  | Direction | Handshake                  | Beat
// ---------+-----------+----------------------------+---------------------
// in       | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
// out      | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
// The entry store is a RAM with one read port, scanned one entry per cycle. An item
// is accepted, then scans entries in order up to the deciding one (a reject or a zero
// address decides at the first step); a translate hit adds a final step that forms
// the rebased result. Reset (synchronous, active low) clears all valid marks at once.
// A stalled output holds its beat; the next item is taken while it waits and stops
// only at the step that would produce its result.
module buffer_range_translation_table #(
    parameter int ENTRIES   = brtt_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS = brtt_pkg::ADDR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  brtt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output brtt_pkg::t_out_item o_out_data
);

    brtt_pkg::t_dp_cmd    ctrl_cmd;
    brtt_pkg::t_dp_status dp_status;

    // Sequencer.
    brtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.cmd),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd),
        .o_in_stall (o_in_stall)
    );

    // Entry store, compare logic and output register.
    brtt_dp #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // A result is loaded only when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.res_load |-> dp_status.out_free)
        else $error("result loaded while output register is still held");

    // An entry is written only by an accepted insert that has a slot.
    a_write_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.wr_en |-> (!dp_status.reject &&
                            (dp_status.ins_match || dp_status.have_free) &&
                            ctrl_cmd.res_load))
        else $error("entry written without a legal slot");

    // After an item is accepted the input side is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after an accept");

    // A loaded result shows up on the output in the next cycle.
    a_result_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.res_load |=> o_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

@@ tb/brtt_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the translation table, keeps its own copy of the
// mapping store, and compares every result beat with the oldest prediction.
module brtt_checker #(
    parameter int ENTRIES = brtt_pkg::ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  brtt_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  brtt_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    // Shadow copy of the mapping store.
    bit          slot_used [ENTRIES];
    logic [31:0] slot_key  [ENTRIES];
    logic [31:0] slot_src  [ENTRIES];
    logic [31:0] slot_tgt  [ENTRIES];
    logic [31:0] slot_len  [ENTRIES];

    brtt_pkg::t_out_item pending_results[$];
    int                  fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    // Applies one command to the shadow store and returns the result it yields.
    function automatic brtt_pkg::t_out_item table_result(input brtt_pkg::t_in_item it);
        brtt_pkg::t_out_item r;
        int                  hit;
        int                  free_idx;
        logic [63:0]         prod;
        logic [31:0]         end_addr;
        r        = '0;
        hit      = -1;
        free_idx = -1;
        if (it.cmd == brtt_pkg::CMD_INSERT) begin
            prod = 64'(it.buffer_bytes) * 64'(it.buffer_count);
            if (it.handle[31] || it.source_base == '0 || it.target_base == '0 ||
                it.buffer_count == '0 || prod > 64'hFFFF_FFFF) begin
                r.status = brtt_pkg::STATUS_REJECT;
            end else begin
                // The first entry matching by key or by source base wins; otherwise
                // the lowest free entry is taken.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_used[i]) begin
                        if (hit < 0 && (slot_key[i] == it.handle ||
                                        slot_src[i] == it.source_base)) begin
                            hit = i;
                        end
                    end else if (free_idx < 0) begin
                        free_idx = i;
                    end
                end
                if (hit < 0) begin
                    hit = free_idx;
                end
                if (hit < 0) begin
                    r.status = brtt_pkg::STATUS_FULL;
                end else begin
                    slot_used[hit] = 1'b1;
                    slot_key[hit]  = it.handle;
                    slot_src[hit]  = it.source_base;
                    slot_tgt[hit]  = it.target_base;
                    slot_len[hit]  = prod[31:0];
                    r.status       = brtt_pkg::STATUS_OK;
                    r.slot_index   = brtt_pkg::t_slot'(hit);
                end
            end
        end else begin
            // Empty, unmapped and wrapping ranges never match.
            if (it.lookup_addr != '0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (hit < 0 && slot_used[i] && slot_src[i] != '0 &&
                        slot_tgt[i] != '0 && slot_len[i] != '0) begin
                        end_addr = slot_src[i] + slot_len[i];
                        if (end_addr >= slot_src[i] && it.lookup_addr >= slot_src[i] &&
                            it.lookup_addr < end_addr) begin
                            hit = i;
                        end
                    end
                end
            end
            if (hit < 0) begin
                r.status      = brtt_pkg::STATUS_MISS;
                r.result_addr = it.lookup_addr;
            end else begin
                r.status      = brtt_pkg::STATUS_OK;
                r.result_addr = slot_tgt[hit] + (it.lookup_addr - slot_src[hit]);
                r.slot_index  = brtt_pkg::t_slot'(hit);
            end
        end
        return r;
    endfunction

    // Result beats are checked before the input beat of the same edge is predicted.
    always @(posedge i_clk) begin : watch
        brtt_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i] = 1'b0;
            end
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no prediction waiting: status %0d addr %h",
                           i_out_data.status, i_out_data.result_addr);
                    fail_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, i_out_data.status);
                        fail_cnt++;
                    end
                    if (i_out_data.result_addr !== want.result_addr) begin
                        $error("result_addr: expected %h, got %h",
                               want.result_addr, i_out_data.result_addr);
                        fail_cnt++;
                    end
                    if (i_out_data.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, i_out_data.slot_index);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(table_result(i_in_data));
            end
        end
        // Registered so that the stimulus reads a settled count after each edge.
        o_pending <= pending_results.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    brtt_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_stall = 1'b0;
    brtt_pkg::t_out_item out_data;
    int                  fail_count;
    int                  pending_count;

    // Idling state of receiver and sender, and the watchdog's idle count.
    int  stall_left  = 0;
    bit  stall_quiet = 1'b0;
    bit  send_quiet  = 1'b0;
    int  idle_cycles = 0;

    // Source bases shared by the random inserts so that updates and hits occur.
    logic [31:0] src_pool[16];
    // Ranges that were sent in plausible inserts, used to aim translations.
    logic [31:0] range_base[$];
    logic [31:0] range_len[$];

    buffer_range_translation_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    brtt_checker mapping_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Receiver stalls in runs of random length, or not at all in quiet stretches.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!stall_quiet && $urandom_range(0, 99) < 35) begin
            out_stall  <= 1'b1;
            stall_left <= gap_len();
        end else begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("buffer_range_translation_table verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic brtt_pkg::t_in_item mk_insert(input logic [31:0] key,
                                                     input logic [31:0] src,
                                                     input logic [31:0] tgt,
                                                     input logic [31:0] bytes,
                                                     input logic [31:0] count);
        brtt_pkg::t_in_item it;
        it.cmd          = brtt_pkg::CMD_INSERT;
        it.handle       = key;
        it.source_base  = src;
        it.target_base  = tgt;
        it.buffer_bytes = bytes;
        it.buffer_count = count;
        it.lookup_addr  = $urandom;
        return it;
    endfunction

    function automatic brtt_pkg::t_in_item mk_translate(input logic [31:0] addr);
        brtt_pkg::t_in_item it;
        it.cmd          = brtt_pkg::CMD_TRANSLATE;
        it.handle       = $urandom;
        it.source_base  = $urandom;
        it.target_base  = $urandom;
        it.buffer_bytes = $urandom;
        it.buffer_count = $urandom;
        it.lookup_addr  = addr;
        return it;
    endfunction

    // Random insert: keys and bases mostly from small pools, sizes mostly small.
    function automatic brtt_pkg::t_in_item rand_insert();
        logic [31:0] key;
        logic [31:0] src;
        logic [31:0] tgt;
        logic [31:0] bytes;
        logic [31:0] count;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 85) key = $urandom_range(0, 23);
        else if (r < 92) key = $urandom;
        else if (r < 95) key = 32'h7FFF_FFFF;
        else if (r < 98) key = 32'hFFFF_FFFF;
        else key = 32'h8000_0000;
        r = $urandom_range(0, 99);
        if (r < 88) src = src_pool[$urandom_range(0, 15)];
        else if (r < 95) src = $urandom;
        else src = '0;
        tgt = ($urandom_range(0, 99) < 4) ? 32'h0 : 32'($urandom);
        case ($urandom_range(0, 9))
            6: begin
                bytes = '0;
                count = $urandom_range(1, 8);
            end
            7: begin
                bytes = 32'd1;
                count = $urandom;
            end
            8: begin
                bytes = $urandom;
                count = $urandom;
            end
            9: begin
                bytes = $urandom;
                count = $urandom_range(0, 1);
            end
            default: begin
                bytes = $urandom_range(1, 4096);
                count = $urandom_range(1, 8);
            end
        endcase
        return mk_insert(key, src, tgt, bytes, count);
    endfunction

    // Lookup address aimed at the start, the last byte, just past the end, or inside
    // a range that was sent earlier; sometimes zero or fully random.
    function automatic logic [31:0] pick_lookup();
        int          r;
        int          idx;
        logic [31:0] base;
        logic [31:0] len;
        logic [31:0] rnd;
        r = $urandom_range(0, 99);
        if (range_base.size() == 0 || r < 15) return $urandom;
        if (r < 20) return '0;
        idx  = $urandom_range(0, range_base.size() - 1);
        base = range_base[idx];
        len  = range_len[idx];
        rnd  = $urandom;
        case ($urandom_range(0, 3))
            0: return base;
            1: return base + len - 32'd1;
            2: return base + len;
            default: return base + ((len == '0) ? 32'd0 : rnd % len);
        endcase
    endfunction

    // Offers one beat after a random gap, none when sending is quiet, and returns once it is accepted.
    task automatic send_beat(input brtt_pkg::t_in_item it);
        int gap;
        gap = send_quiet ? 0 : gap_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (it.cmd == brtt_pkg::CMD_INSERT && !it.handle[31] && it.source_base != '0) begin
            range_base.push_back(it.source_base);
            range_len.push_back(it.buffer_bytes * it.buffer_count);
        end
    endtask

    // Holds the sender off until every predicted result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    task automatic pick_idle_mode();
        send_quiet = ($urandom_range(0, 3) == 0);
        stall_quiet <= ($urandom_range(0, 3) == 0);
    endtask

    initial begin
        in_valid = 1'b0;
        in_data  = '0;
        rst_n    = 1'b0;
        for (int i = 0; i < 15; i++) begin
            src_pool[i] = $urandom & 32'hFFFF_F000;
        end
        src_pool[15] = 32'hFFFF_FF80;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, every reject reason, size extremes, wrapping and
        // empty ranges, updates by key and by source base, address extremes.
        send_beat(mk_translate(32'h0));
        send_beat(mk_translate(32'h0000_1234));
        send_beat(mk_insert(32'hFFFF_FFFF, 32'h1000, 32'h2000, 32'h10, 32'h1));
        send_beat(mk_insert(32'h8000_0000, 32'h1000, 32'h2000, 32'h10, 32'h1));
        send_beat(mk_insert(32'h1, 32'h0, 32'h2000, 32'h10, 32'h1));
        send_beat(mk_insert(32'h1, 32'h1000, 32'h0, 32'h10, 32'h1));
        send_beat(mk_insert(32'h1, 32'h1000, 32'h2000, 32'h10, 32'h0));
        send_beat(mk_insert(32'h1, 32'h1000, 32'h2000, 32'h0001_0000, 32'h0001_0000));
        send_beat(mk_insert(32'h7FFF_FFFF, 32'h1000, 32'h9000_0000, 32'hFFFF, 32'h0001_0001));
        send_beat(mk_insert(32'h0, 32'h0001_0000, 32'hFFFF_FFF0, 32'h100, 32'h2));
        send_beat(mk_translate(32'h0001_0000));
        send_beat(mk_translate(32'h0001_01FF));
        send_beat(mk_translate(32'h0001_0200));
        send_beat(mk_insert(32'h5, 32'h0002_0000, 32'h3000, 32'h0, 32'h7));
        send_beat(mk_translate(32'h0002_0000));
        send_beat(mk_insert(32'h6, 32'hFFFF_F000, 32'h5000, 32'h1000, 32'h1));
        send_beat(mk_translate(32'hFFFF_F800));
        send_beat(mk_insert(32'h0, 32'h0003_0000, 32'h7000, 32'h10, 32'h10));
        send_beat(mk_translate(32'h0001_0000));
        send_beat(mk_translate(32'h0003_00FF));
        send_beat(mk_insert(32'h9, 32'h0003_0000, 32'hAAAA_0000, 32'h1, 32'h100));
        send_beat(mk_translate(32'h0003_0080));
        send_beat(mk_translate(32'hFFFF_FFFF));
        send_beat(mk_insert(32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h1, 32'h1));
        send_beat(mk_translate(32'hFFFF_FFFE));
        drain_results();

        // Random mix on a table that stays well below capacity.
        for (int n = 0; n < 250; n++) begin
            if (n % 40 == 0) pick_idle_mode();
            if (n == 125) drain_results();
            if ($urandom_range(0, 99) < 45) send_beat(rand_insert());
            else send_beat(mk_translate(pick_lookup()));
        end
        drain_results();

        // Fill the table with fresh keys and bases, more inserts than it has entries, so that it reports full.
        for (int n = 0; n < 70; n++) begin
            if (n % 40 == 0) pick_idle_mode();
            if ($urandom_range(0, 2) == 0) send_beat(mk_translate(pick_lookup()));
            send_beat(mk_insert(32'h4000_0000 + n, 32'h8000_0000 + (n << 16), $urandom,
                                $urandom_range(1, 32'h8000), 32'h1));
        end

        // Random mix on the full table: updates, full reports and lookups.
        for (int n = 0; n < 80; n++) begin
            if (n % 40 == 0) pick_idle_mode();
            if ($urandom_range(0, 1) == 0) send_beat(rand_insert());
            else send_beat(mk_translate(pick_lookup()));
        end
        drain_results();
        repeat (brtt_pkg::ENTRIES_DEF + 8) @(posedge clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("buffer_range_translation_table verification clean");
        end else begin
            $display("buffer_range_translation_table verification failed");
        end
        $finish;
    end

endmodule

@@ buffer_range_translation_table.f @@
rtl/brtt_pkg.sv
rtl/brtt_ram.sv
rtl/brtt_dp.sv
rtl/brtt_ctrl.sv
rtl/buffer_range_translation_table.sv
tb/brtt_checker.sv
tb/testbench.sv
